[design/hrp_pkg.sv]
// Shared types, codes and the per-byte field classifier for the HTTP request head parser.
// Used by hrp_step, hrp_out_queue, http_request_head_parser and its testbench; depends on nothing else.
package hrp_pkg;

  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_HSTART  = 3'd3;
  localparam logic [2:0] PH_HNAME   = 3'd4;
  localparam logic [2:0] PH_VLEAD   = 3'd5;
  localparam logic [2:0] PH_VALUE   = 3'd6;

  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_METHOD  = 3'd1;
  localparam logic [2:0] K_PATH    = 3'd2;
  localparam logic [2:0] K_VERSION = 3'd3;
  localparam logic [2:0] K_HNAME   = 3'd4;
  localparam logic [2:0] K_HVALUE  = 3'd5;

  localparam logic [2:0] ST_RUN        = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_NO_EOL     = 3'd2;
  localparam logic [2:0] ST_NO_SP1     = 3'd3;
  localparam logic [2:0] ST_NO_SP2     = 3'd4;
  localparam logic [2:0] ST_BAD_VER    = 3'd5;
  localparam logic [2:0] ST_HDR_UNTERM = 3'd6;
  localparam logic [2:0] ST_NO_COLON   = 3'd7;

  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [2:0] VER_PREFIX_LEN = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic       cr_held;
    logic [2:0] vcount;
    logic       vmis;
    logic [2:0] lstatus;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic [2:0] closes;
    logic [2:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [2:0] kind;
    logic [2:0] closes;
    logic [2:0] phase;
    logic [2:0] vcount;
    logic       vmis;
  } content_t;

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      default: c = 8'h2F;
    endcase
    return c;
  endfunction

  function automatic content_t content_step(input logic [2:0] phase, input logic [2:0] vcount,
                                            input logic vmis, input logic [7:0] b);
    content_t r;
    r.emit   = 1'b1;
    r.data   = 8'd0;
    r.kind   = K_NONE;
    r.closes = K_NONE;
    r.phase  = phase;
    r.vcount = vcount;
    r.vmis   = vmis;
    unique case (phase)
      PH_METHOD: begin
        if (b == CHAR_SP) begin
          r.closes = K_METHOD;
          r.phase  = PH_PATH;
        end else begin
          r.kind = K_METHOD;
          r.data = b;
        end
      end
      PH_PATH: begin
        if (b == CHAR_SP) begin
          r.closes = K_PATH;
          r.phase  = PH_VERSION;
        end else begin
          r.kind = K_PATH;
          r.data = b;
        end
      end
      PH_VERSION: begin
        if (vcount < VER_PREFIX_LEN) begin
          if (b != ver_char(vcount)) r.vmis = 1'b1;
          r.vcount = vcount + 3'd1;
        end
        r.kind = K_VERSION;
        r.data = b;
      end
      PH_HSTART, PH_HNAME: begin
        if (b == CHAR_COLON) begin
          r.closes = K_HNAME;
          r.phase  = PH_VLEAD;
        end else begin
          r.kind  = K_HNAME;
          r.data  = b;
          r.phase = PH_HNAME;
        end
      end
      PH_VLEAD: begin
        if (b != CHAR_SP) begin
          r.kind  = K_HVALUE;
          r.data  = b;
          r.phase = PH_VALUE;
        end else begin
          r.emit = 1'b0;
        end
      end
      default: begin
        r.kind = K_HVALUE;
        r.data = b;
      end
    endcase
    return r;
  endfunction

endpackage

[design/http_request_head_parser.sv]
// Top level of the HTTP request head parser: parse state registers, step logic and result queue.
// Depends on hrp_pkg, hrp_step and hrp_out_queue.
//
// The parser takes one byte of a request head per accepted item and produces one or two
// result items per byte, each tagged with its field, any field end and the running status.
// It accepts a new byte every cycle while its four-entry result queue has room for two
// results, so a stream of bytes that each give one result moves at one byte per clock
// while out_ready is held high; a byte that gives two results fills two queue entries.
// The status is final on the last result of the byte flagged as the end of the message,
// after which the parser starts over for the next message.
module http_request_head_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] field_kind,
  output logic [2:0] closes_field,
  output logic [2:0] status,
  output logic       last_of_run
);
  import hrp_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  result_t      res0;
  result_t      res1;
  result_t      head;
  logic         two;
  logic         room;
  logic         accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  hrp_step u_step (
    .st             (st),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .st_next        (st_next),
    .res0           (res0),
    .res1           (res1),
    .two            (two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase   <= PH_METHOD;
      st.cr_held <= 1'b0;
      st.vcount  <= 3'd0;
      st.vmis    <= 1'b0;
      st.lstatus <= ST_RUN;
    end else if (accept) begin
      st <= st_next;
    end
  end

  hrp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .two       (two),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte     = head.data;
  assign field_kind   = head.kind;
  assign closes_field = head.closes;
  assign status       = head.status;
  assign last_of_run  = head.last;

endmodule

[design/hrp_step.sv]
// Combinational handling of one input byte: CR holding, field classification and line ends.
// Depends on hrp_pkg for the state and result types and the classifier function.
module hrp_step (
  input  hrp_pkg::parse_state_t st,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_message,
  output hrp_pkg::parse_state_t st_next,
  output hrp_pkg::result_t      res0,
  output hrp_pkg::result_t      res1,
  output logic                  two
);
  import hrp_pkg::*;

  logic       run;
  logic       do1;
  logic       do2;
  logic [7:0] b1;
  logic [7:0] b2;
  logic       hold;
  logic       le;
  logic       le_emit;
  logic [2:0] le_closes;
  logic [2:0] le_status;
  logic [2:0] le_phase;
  content_t   c1;
  content_t   c2;
  content_t   cf;
  logic       e1;
  logic [2:0] phase_mid;
  logic [2:0] status_mid;
  logic [2:0] status_out;

  assign run = (st.lstatus == ST_RUN);

  always_comb begin
    do1  = 1'b0;
    do2  = 1'b0;
    b1   = data_byte;
    b2   = data_byte;
    hold = 1'b0;
    le   = 1'b0;
    if (run) begin
      if (st.cr_held) begin
        if (data_byte == CHAR_LF) begin
          le = 1'b1;
        end else begin
          do1 = 1'b1;
          b1  = CHAR_CR;
          if (data_byte == CHAR_CR) hold = 1'b1;
          else do2 = 1'b1;
        end
      end else if (data_byte == CHAR_CR) begin
        hold = 1'b1;
      end else begin
        do1 = 1'b1;
      end
    end
    // A CR still held at the end of the message is delivered as content.
    if (end_of_message && hold) begin
      if (do1) begin
        do2 = 1'b1;
        b2  = CHAR_CR;
      end else begin
        do1 = 1'b1;
        b1  = CHAR_CR;
      end
    end
  end

  assign c1 = content_step(st.phase, st.vcount, st.vmis, b1);
  assign c2 = content_step(c1.phase, c1.vcount, c1.vmis, b2);

  always_comb begin
    cf = c1;
    if (do2) begin
      cf = c2;
    end else if (!do1) begin
      cf.phase  = st.phase;
      cf.vcount = st.vcount;
      cf.vmis   = st.vmis;
    end
  end

  always_comb begin
    le_emit   = 1'b0;
    le_closes = K_NONE;
    le_status = ST_RUN;
    le_phase  = st.phase;
    unique case (st.phase)
      PH_METHOD: le_status = ST_NO_SP1;
      PH_PATH:   le_status = ST_NO_SP2;
      PH_VERSION: begin
        le_emit   = 1'b1;
        le_closes = K_VERSION;
        if (st.vcount == VER_PREFIX_LEN && !st.vmis) le_phase = PH_HSTART;
        else le_status = ST_BAD_VER;
      end
      PH_HSTART: le_status = ST_DONE;
      PH_HNAME:  le_status = ST_NO_COLON;
      default: begin
        le_emit   = 1'b1;
        le_closes = K_HVALUE;
        le_phase  = PH_HSTART;
      end
    endcase
  end

  assign phase_mid  = le ? le_phase : cf.phase;
  assign status_mid = le ? le_status : ST_RUN;

  always_comb begin
    if (!run) begin
      status_out = st.lstatus;
    end else if (end_of_message && status_mid == ST_RUN) begin
      status_out = (phase_mid <= PH_VERSION) ? ST_NO_EOL : ST_HDR_UNTERM;
    end else begin
      status_out = status_mid;
    end
  end

  assign e1  = do1 && c1.emit;
  assign two = !le && e1 && do2 && c2.emit;

  always_comb begin
    res0.data   = 8'd0;
    res0.kind   = K_NONE;
    res0.closes = K_NONE;
    if (le) begin
      if (le_emit) res0.closes = le_closes;
    end else if (e1) begin
      res0.data   = c1.data;
      res0.kind   = c1.kind;
      res0.closes = c1.closes;
    end else if (do2 && c2.emit) begin
      res0.data   = c2.data;
      res0.kind   = c2.kind;
      res0.closes = c2.closes;
    end
    res0.status = status_out;
    res0.last   = !two;
    res1.data   = c2.data;
    res1.kind   = c2.kind;
    res1.closes = c2.closes;
    res1.status = status_out;
    res1.last   = 1'b1;
  end

  always_comb begin
    if (end_of_message) begin
      st_next.phase   = PH_METHOD;
      st_next.cr_held = 1'b0;
      st_next.vcount  = 3'd0;
      st_next.vmis    = 1'b0;
      st_next.lstatus = ST_RUN;
    end else begin
      st_next.phase   = phase_mid;
      st_next.cr_held = run ? hold : st.cr_held;
      st_next.vcount  = le ? st.vcount : cf.vcount;
      st_next.vmis    = le ? st.vmis : cf.vmis;
      st_next.lstatus = status_out;
    end
  end

endmodule

[design/hrp_out_queue.sv]
// Four-entry result queue that takes one or two results per cycle and delivers one while out_ready is high.
// Depends on hrp_pkg for the result type.
module hrp_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             two,
  input  hrp_pkg::result_t res0,
  input  hrp_pkg::result_t res1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output hrp_pkg::result_t head
);
  import hrp_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  assign count_next = count + {2'd0, push} + {2'd0, push && two} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= res0;
      if (two) mem[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + (two ? 2'd2 : 2'd1);
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

endmodule

[test/http_request_head_parser_tb.sv]
// Self-checking testbench for http_request_head_parser: directed and random request heads,
// with each result compared against a byte-level parser model kept in this file.
// Depends on hrp_pkg for the field, status and character codes and the result_t layout.
module http_request_head_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrp_pkg::*;

  localparam logic [39:0] HTTP_PREFIX = "HTTP/";
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 50000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] field_kind;
  logic [2:0] closes_field;
  logic [2:0] status;
  logic       last_of_run;

  logic [2:0] pr_phase = PH_METHOD;
  logic       pr_cr = 1'b0;
  logic [2:0] pr_vcount = 3'd0;
  logic       pr_vmis = 1'b0;
  logic [2:0] pr_status = ST_RUN;

  result_t    byte_results[$];
  result_t    pending_results[$];
  logic [7:0] msg_bytes[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 69;
  int parsed_items = 0;
  int fail_count = 0;
  int hold_left = 0;
  bit hold_start = 1'b0;

  http_request_head_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .field_kind     (field_kind),
    .closes_field   (closes_field),
    .status         (status),
    .last_of_run    (last_of_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void clear_parse_state();
    pr_phase  = PH_METHOD;
    pr_cr     = 1'b0;
    pr_vcount = 3'd0;
    pr_vmis   = 1'b0;
    pr_status = ST_RUN;
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] b,
                                     input logic [2:0] closes);
    result_t r;
    if (byte_results.size() < 2) begin
      r.data   = (kind != K_NONE) ? b : 8'h00;
      r.kind   = kind;
      r.closes = closes;
      r.status = ST_RUN;
      r.last   = 1'b0;
      byte_results.push_back(r);
    end
  endfunction

  function automatic void tag_byte(input logic [7:0] b);
    case (pr_phase)
      PH_METHOD: begin
        if (b == CHAR_SP) begin
          add_result(K_NONE, 8'h00, K_METHOD);
          pr_phase = PH_PATH;
        end else begin
          add_result(K_METHOD, b, K_NONE);
        end
      end
      PH_PATH: begin
        if (b == CHAR_SP) begin
          add_result(K_NONE, 8'h00, K_PATH);
          pr_phase = PH_VERSION;
        end else begin
          add_result(K_PATH, b, K_NONE);
        end
      end
      PH_VERSION: begin
        if (pr_vcount < VER_PREFIX_LEN) begin
          if (b != HTTP_PREFIX[8 * (4 - pr_vcount) +: 8]) pr_vmis = 1'b1;
          pr_vcount = pr_vcount + 3'd1;
        end
        add_result(K_VERSION, b, K_NONE);
      end
      PH_HSTART, PH_HNAME: begin
        if (b == CHAR_COLON) begin
          add_result(K_NONE, 8'h00, K_HNAME);
          pr_phase = PH_VLEAD;
        end else begin
          add_result(K_HNAME, b, K_NONE);
          pr_phase = PH_HNAME;
        end
      end
      PH_VLEAD: begin
        if (b != CHAR_SP) begin
          add_result(K_HVALUE, b, K_NONE);
          pr_phase = PH_VALUE;
        end
      end
      default: begin
        add_result(K_HVALUE, b, K_NONE);
      end
    endcase
  endfunction

  function automatic void end_line();
    case (pr_phase)
      PH_METHOD: pr_status = ST_NO_SP1;
      PH_PATH:   pr_status = ST_NO_SP2;
      PH_VERSION: begin
        add_result(K_NONE, 8'h00, K_VERSION);
        if (pr_vcount == VER_PREFIX_LEN && !pr_vmis) pr_phase = PH_HSTART;
        else pr_status = ST_BAD_VER;
      end
      PH_HSTART: pr_status = ST_DONE;
      PH_HNAME:  pr_status = ST_NO_COLON;
      default: begin
        add_result(K_NONE, 8'h00, K_HVALUE);
        pr_phase = PH_HSTART;
      end
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eom);
    byte_results.delete();
    parsed_items++;
    if (pr_status == ST_RUN) begin
      if (pr_cr) begin
        pr_cr = 1'b0;
        if (b == CHAR_LF) begin
          end_line();
        end else begin
          tag_byte(CHAR_CR);
          if (b == CHAR_CR) pr_cr = 1'b1;
          else tag_byte(b);
        end
      end else if (b == CHAR_CR) begin
        pr_cr = 1'b1;
      end else begin
        tag_byte(b);
      end
    end
    if (eom && pr_status == ST_RUN) begin
      if (pr_cr) begin
        pr_cr = 1'b0;
        tag_byte(CHAR_CR);
      end
      pr_status = (pr_phase <= PH_VERSION) ? ST_NO_EOL : ST_HDR_UNTERM;
    end
    if (byte_results.size() == 0) add_result(K_NONE, 8'h00, K_NONE);
    foreach (byte_results[k]) begin
      byte_results[k].status = pr_status;
      byte_results[k].last   = (k == byte_results.size() - 1);
      pending_results.push_back(byte_results[k]);
    end
    if (eom) clear_parse_state();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, eom);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    msg_bytes.push_back(CHAR_CR);
    msg_bytes.push_back(CHAR_LF);
  endfunction

  function automatic logic [7:0] noisy_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0:       b = CHAR_SP;
      1:       b = CHAR_COLON;
      2:       b = CHAR_CR;
      3:       b = CHAR_LF;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  function automatic void put_token(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) msg_bytes.push_back(8'($urandom_range(90, 65)));
  endfunction

  function automatic void put_printable(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) msg_bytes.push_back(8'($urandom_range(126, 33)));
  endfunction

  function automatic void build_request();
    int headers;
    int value_len;
    msg_bytes.delete();
    put_token(1, 6);
    msg_bytes.push_back(CHAR_SP);
    put_text("/");
    put_printable(0, 6);
    msg_bytes.push_back(CHAR_SP);
    if ($urandom_range(9) == 0) put_printable(0, 7);
    else put_text("HTTP/1.1");
    put_crlf();
    headers = $urandom_range(3);
    repeat (headers) begin
      put_token(0, 6);
      msg_bytes.push_back(CHAR_COLON);
      repeat ($urandom_range(2)) msg_bytes.push_back(CHAR_SP);
      value_len = $urandom_range(6);
      repeat (value_len) begin
        case ($urandom_range(11))
          0:       msg_bytes.push_back(CHAR_CR);
          1:       msg_bytes.push_back(CHAR_SP);
          2:       msg_bytes.push_back(CHAR_COLON);
          default: msg_bytes.push_back(8'($urandom_range(126, 33)));
        endcase
      end
      put_crlf();
    end
    put_crlf();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) msg_bytes.push_back(noisy_byte());
    end
  endfunction

  task automatic send_random_message();
    int cut;
    build_request();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: begin
          cut = $urandom_range(msg_bytes.size() - 1);
          while (msg_bytes.size() > cut + 1) void'(msg_bytes.pop_back());
        end
        1: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = noisy_byte();
        2: msg_bytes.delete($urandom_range(msg_bytes.size() - 1));
        default: begin
          msg_bytes.delete();
          repeat ($urandom_range(12, 1)) msg_bytes.push_back(noisy_byte());
        end
      endcase
    end
    send_message();
  endtask

  task automatic test_line_end_errors();
    msg_bytes = {CHAR_SP, CHAR_CR, CHAR_LF};
    send_message();
    msg_bytes = {CHAR_CR, CHAR_CR, CHAR_LF};
    send_message();
  endtask

  task automatic test_held_cr_at_end();
    msg_bytes = {8'hFF, 8'h00, CHAR_CR};
    send_message();
  endtask

  task automatic test_empty_fields_and_done();
    msg_bytes = {CHAR_SP, CHAR_SP};
    put_text("HTTP/");
    put_crlf();
    msg_bytes.push_back(CHAR_COLON);
    put_crlf();
    put_crlf();
    put_text("Z");
    send_message();
  endtask

  task automatic test_version_check();
    msg_bytes = {CHAR_SP, CHAR_SP};
    put_text("H");
    put_crlf();
    send_message();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int goal;
    goal = parsed_items + count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (parsed_items < goal) send_random_message();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start <= 1'b1;
    repeat (3) send_random_message();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_start <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected item: byte %02h kind %0d closes %0d status %0d last %0d",
                               out_byte, field_kind, closes_field, status, last_of_run));
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data || field_kind !== want.kind || closes_field !== want.closes ||
            status !== want.status || last_of_run !== want.last) begin
          note_failure($sformatf(
            "expected byte %02h kind %0d closes %0d status %0d last %0d, got %02h %0d %0d %0d %0d",
            want.data, want.kind, want.closes, want.status, want.last,
            out_byte, field_kind, closes_field, status, last_of_run));
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_line_end_errors();
    test_held_cr_at_end();
    test_empty_fields_and_done();
    test_version_check();
    test_random_traffic(23, 69, 340);
    test_random_traffic(69, 23, 340);
    test_output_stall();
    test_random_traffic(0, 0, 330);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d expected items never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
